### sv/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam int CHAR_WIDTH     = 8;
   localparam int POS_WIDTH      = 8;
   localparam int MAXLEN_WIDTH   = 9;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_LSB  = 2;

   // register index (byte address / 4)
   localparam logic CSR_IDX_MAX_LENGTH = 1'b0;

   localparam logic [MAXLEN_WIDTH-1:0] MAXLEN_RESET = 9'd256;

   // key codes
   localparam logic [CHAR_WIDTH-1:0] KEY_BACKSPACE   = 8'd8;
   localparam logic [CHAR_WIDTH-1:0] KEY_CURSOR_BACK = 8'd248;
   localparam logic [CHAR_WIDTH-1:0] KEY_CURSOR_FWD  = 8'd251;
   localparam logic [CHAR_WIDTH-1:0] KEY_DELETE      = 8'd252;
   localparam logic [CHAR_WIDTH-1:0] PRINT_LOW       = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] PRINT_HIGH      = 8'd126;

   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_COMMIT,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_BACKSPACE,
      OP_DELETE,
      OP_INSERT
   } op_type;

endpackage

### sv/leb_req_if.sv
// ----------------------------------------------------------------------------
// leb_req_if
// Request channel: key event or buffer read, valid/ready handshake.
// ----------------------------------------------------------------------------
interface leb_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic [leb_pkg::CHAR_WIDTH-1:0]  key;
   logic [leb_pkg::POS_WIDTH-1:0]   read_index;

   modport source (output valid, output mode, output key, output read_index, input ready);
   modport sink   (input valid, input mode, input key, input read_index, output ready);
endinterface

### sv/leb_rsp_if.sv
// ----------------------------------------------------------------------------
// leb_rsp_if
// Response channel: editor status after each request.
// ----------------------------------------------------------------------------
interface leb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            handled;
   logic [leb_pkg::POS_WIDTH-1:0]   cursor_pos;
   logic [leb_pkg::POS_WIDTH-1:0]   text_length;
   logic [leb_pkg::CHAR_WIDTH-1:0]  read_char;

   modport source (output valid, output handled, output cursor_pos, output text_length,
                   output read_char, input ready);
   modport sink   (input valid, input handled, input cursor_pos, input text_length,
                   input read_char, output ready);
endinterface

### sv/leb_ram.sv
// ----------------------------------------------------------------------------
// leb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_unit
// One-line text buffer with cursor: insert, delete, cursor moves and reads.
// ----------------------------------------------------------------------------
// Each request is a key event or a read of one buffer position, and yields
// exactly one response with the handled flag, cursor, length and (for reads)
// the character. The block takes one request at a time: cursor moves and
// unhandled keys go straight to the response state, reads pass through the
// RAM read state, and backspace, delete and insert run the shift loop over
// the N characters moved (up to 254 at full capacity), then commit. The move
// rate is set by the text RAM, which does one read and one write per cycle;
// the shift loop streams one character per cycle through it. A finished
// response sits in an output register, so a new request is accepted while it
// waits; the block only stalls before loading the next response. Capacity is
// min(max_length, BUFFER_DEPTH); the text holds at most capacity - 1
// characters. No clearing pass is needed after reset: only positions below
// the length are ever used, and those were always written.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   leb_req_if.sink                               req_bus,
   leb_rsp_if.source                             rsp_bus,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [leb_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [leb_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [leb_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);

   localparam int ADDR_WIDTH = $clog2(BUFFER_DEPTH);
   localparam logic [leb_pkg::MAXLEN_WIDTH-1:0] DEPTH_CAP =
      leb_pkg::MAXLEN_WIDTH'(BUFFER_DEPTH);

   // ---- state ----
   leb_pkg::state_type                   state_ff, state_in;
   leb_pkg::op_type                      op_ff, op_in;
   logic [leb_pkg::POS_WIDTH-1:0]        cursor_ff, cursor_in;
   logic [leb_pkg::POS_WIDTH-1:0]        length_ff, length_in;
   logic [leb_pkg::POS_WIDTH-1:0]        ptr_ff, ptr_in;       // shift destination
   logic                                 up_ff, up_in;         // 1: insert (tail moves up)
   logic                                 wr_pend_ff, wr_pend_in;
   logic [leb_pkg::POS_WIDTH-1:0]        wr_addr_ff, wr_addr_in;
   logic [leb_pkg::CHAR_WIDTH-1:0]       key_ff, key_in;
   logic                                 handled_ff, handled_in;
   logic                                 rd_hit_ff, rd_hit_in;
   logic [leb_pkg::CHAR_WIDTH-1:0]       rchar_ff, rchar_in;
   logic [leb_pkg::MAXLEN_WIDTH-1:0]     max_length_ff, max_length_in;

   // ---- response register ----
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_handled_ff, out_handled_in;
   logic [leb_pkg::POS_WIDTH-1:0]        out_cursor_ff, out_cursor_in;
   logic [leb_pkg::POS_WIDTH-1:0]        out_length_ff, out_length_in;
   logic [leb_pkg::CHAR_WIDTH-1:0]       out_rchar_ff, out_rchar_in;

   // ---- datapath ----
   logic [leb_pkg::MAXLEN_WIDTH-1:0]     capacity;
   logic [leb_pkg::MAXLEN_WIDTH-1:0]     step;       // shared +/-1 unit
   logic                                 shift_more;
   logic                                 req_accept;
   logic                                 out_free;
   logic                                 load_rsp;
   logic                                 csr_write;
   logic                                 commit_insert;

   logic                                 ram_wr_en;
   logic [ADDR_WIDTH-1:0]                ram_wr_addr;
   logic [leb_pkg::CHAR_WIDTH-1:0]       ram_wr_data;
   logic [ADDR_WIDTH-1:0]                ram_rd_addr;
   logic [leb_pkg::CHAR_WIDTH-1:0]       ram_rd_data;

   // Capacity saturates at the physical depth.
   assign capacity   = (max_length_ff > DEPTH_CAP) ? DEPTH_CAP : max_length_ff;
   assign req_accept = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // The one step unit: next destination and source address of the shift
   // loop. Going down (delete) the source is dst+1, going up (insert) dst-1,
   // and in both cases the next destination equals the current source.
   assign step = up_ff ? ({1'b0, ptr_ff} - 9'd1) : ({1'b0, ptr_ff} + 9'd1);
   assign shift_more = up_ff ? (ptr_ff > cursor_ff) : (step < {1'b0, length_ff});

   assign req_bus.ready = (state_ff == leb_pkg::ST_IDLE);

   // ---- text RAM ----
   // Shift loop is pipelined: the read issued for destination d returns from
   // the registered RAM port and is written then, while the next source is
   // being read. Read and write addresses never collide, and each source is read
   // before it is overwritten.
   assign commit_insert = (state_ff == leb_pkg::ST_COMMIT) && (op_ff == leb_pkg::OP_INSERT);
   assign ram_wr_en   = wr_pend_ff || commit_insert;
   assign ram_wr_addr = commit_insert ? cursor_ff[ADDR_WIDTH-1:0] : wr_addr_ff[ADDR_WIDTH-1:0];
   assign ram_wr_data = commit_insert ? key_ff : ram_rd_data;
   assign ram_rd_addr = (state_ff == leb_pkg::ST_IDLE) ? req_bus.read_index[ADDR_WIDTH-1:0]
                                                       : step[ADDR_WIDTH-1:0];

   leb_ram #(
      .WIDTH (leb_pkg::CHAR_WIDTH),
      .DEPTH (BUFFER_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---- CSR port ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[leb_pkg::CSR_ADDR_WIDTH-1:leb_pkg::CSR_INDEX_LSB] ==
                       leb_pkg::CSR_IDX_MAX_LENGTH);
   assign max_length_in = csr_write ? pwdata[leb_pkg::MAXLEN_WIDTH-1:0] : max_length_ff;

   always_comb begin
      prdata = '0;
      if (paddr[leb_pkg::CSR_ADDR_WIDTH-1:leb_pkg::CSR_INDEX_LSB] ==
          leb_pkg::CSR_IDX_MAX_LENGTH) begin
         prdata = leb_pkg::CSR_DATA_WIDTH'(max_length_ff);
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cursor_in  = cursor_ff;
      length_in  = length_ff;
      ptr_in     = ptr_ff;
      up_in      = up_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      key_in     = key_ff;
      handled_in = handled_ff;
      rd_hit_in  = rd_hit_ff;
      rchar_in   = rchar_ff;
      load_rsp   = 1'b0;

      case (state_ff)
         leb_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in     = req_bus.key;
               op_in      = leb_pkg::OP_NONE;
               handled_in = 1'b0;
               rchar_in   = '0;
               state_in   = leb_pkg::ST_DONE;
               if (req_bus.mode == leb_pkg::MODE_READ) begin
                  // RAM read of read_index is issued this cycle
                  rd_hit_in = (req_bus.read_index < length_ff);
                  state_in  = leb_pkg::ST_READ;
               end else if (capacity >= 9'd2) begin
                  case (req_bus.key) inside
                     leb_pkg::KEY_CURSOR_BACK: begin
                        handled_in = 1'b1;
                        if (cursor_ff != '0) begin
                           cursor_in = cursor_ff - 8'd1;
                        end
                     end
                     leb_pkg::KEY_CURSOR_FWD: begin
                        handled_in = 1'b1;
                        if (cursor_ff < length_ff) begin
                           cursor_in = cursor_ff + 8'd1;
                        end
                     end
                     leb_pkg::KEY_BACKSPACE: begin
                        handled_in = 1'b1;
                        if (cursor_ff != '0) begin
                           op_in    = leb_pkg::OP_BACKSPACE;
                           ptr_in   = cursor_ff - 8'd1;
                           up_in    = 1'b0;
                           state_in = leb_pkg::ST_SHIFT;
                        end
                     end
                     leb_pkg::KEY_DELETE: begin
                        handled_in = 1'b1;
                        if (cursor_ff < length_ff) begin
                           op_in    = leb_pkg::OP_DELETE;
                           ptr_in   = cursor_ff;
                           up_in    = 1'b0;
                           state_in = leb_pkg::ST_SHIFT;
                        end
                     end
                     [leb_pkg::PRINT_LOW:leb_pkg::PRINT_HIGH]: begin
                        handled_in = 1'b1;
                        // refused when full: length + 1 reaches capacity
                        if (({1'b0, length_ff} + 9'd1) < capacity) begin
                           op_in    = leb_pkg::OP_INSERT;
                           ptr_in   = length_ff;
                           up_in    = 1'b1;
                           state_in = leb_pkg::ST_SHIFT;
                        end
                     end
                     default: begin
                        handled_in = 1'b0;
                     end
                  endcase
               end
            end
         end

         leb_pkg::ST_SHIFT: begin
            if (shift_more) begin
               // read source now, write destination next cycle
               wr_pend_in = 1'b1;
               wr_addr_in = ptr_ff;
               ptr_in     = step[leb_pkg::POS_WIDTH-1:0];
            end else begin
               // last pending write (if any) completes this cycle
               state_in = leb_pkg::ST_COMMIT;
            end
         end

         leb_pkg::ST_COMMIT: begin
            case (op_ff)
               leb_pkg::OP_BACKSPACE: begin
                  cursor_in = cursor_ff - 8'd1;
                  length_in = length_ff - 8'd1;
               end
               leb_pkg::OP_DELETE: begin
                  length_in = length_ff - 8'd1;
               end
               leb_pkg::OP_INSERT: begin
                  // key goes into the gap at the cursor (RAM write above)
                  cursor_in = cursor_ff + 8'd1;
                  length_in = length_ff + 8'd1;
               end
               default: begin
               end
            endcase
            state_in = leb_pkg::ST_DONE;
         end

         leb_pkg::ST_READ: begin
            rchar_in = rd_hit_ff ? ram_rd_data : '0;
            state_in = leb_pkg::ST_DONE;
         end

         leb_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = leb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = leb_pkg::ST_IDLE;
         end
      endcase
   end

   // ---- response register ----
   always_comb begin
      out_handled_in = out_handled_ff;
      out_cursor_in  = out_cursor_ff;
      out_length_in  = out_length_ff;
      out_rchar_in   = out_rchar_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         out_handled_in = handled_ff;
         out_cursor_in  = cursor_ff;
         out_length_in  = length_ff;
         out_rchar_in   = rchar_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.handled     = out_handled_ff;
   assign rsp_bus.cursor_pos  = out_cursor_ff;
   assign rsp_bus.text_length = out_length_ff;
   assign rsp_bus.read_char   = out_rchar_ff;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= leb_pkg::ST_IDLE;
         cursor_ff     <= '0;
         length_ff     <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= leb_pkg::MAXLEN_RESET;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         length_ff     <= length_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_length_ff <= max_length_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      ptr_ff         <= ptr_in;
      up_ff          <= up_in;
      wr_addr_ff     <= wr_addr_in;
      key_ff         <= key_in;
      handled_ff     <= handled_in;
      rd_hit_ff      <= rd_hit_in;
      rchar_ff       <= rchar_in;
      out_handled_ff <= out_handled_in;
      out_cursor_ff  <= out_cursor_in;
      out_length_ff  <= out_length_in;
      out_rchar_ff   <= out_rchar_in;
   end

endmodule

### sv/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks for the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_handled,
   input logic [leb_pkg::POS_WIDTH-1:0]   rsp_cursor_pos,
   input logic [leb_pkg::POS_WIDTH-1:0]   rsp_text_length,
   input logic [leb_pkg::CHAR_WIDTH-1:0]  rsp_read_char
);

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("leb: ready still high after request accept");

   // a response appears only after the block was busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("leb: response without preceding work");

   // cursor never passes the end of the text
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_pos <= rsp_text_length))
      else $error("leb: cursor beyond text length");

   // a handled key never carries read data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_handled) |-> (rsp_read_char == '0))
      else $error("leb: read data on a key response");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cursor_pos) &&
                                     $stable(rsp_text_length) && $stable(rsp_read_char)))
      else $error("leb: stalled response changed");

endmodule

bind line_edit_buffer_unit leb_checker u_leb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_handled     (rsp_bus.handled),
   .rsp_cursor_pos  (rsp_bus.cursor_pos),
   .rsp_text_length (rsp_bus.text_length),
   .rsp_read_char   (rsp_bus.read_char)
);
